// ----- rtl/bmed_pkg.sv -----
// ----------------------------------------------------------------------------
// bmed_pkg
// Shared constants, codes and types of the binary mask erode/dilate filter.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package bmed_pkg;

  localparam int MAX_WIDTH_DEF   = 1024;
  localparam int MAX_HEIGHT_DEF  = 1024;
  localparam int ERODE_SIZE_DEF  = 3;
  localparam int DILATE_SIZE_DEF = 7;

  localparam int CFG_DATA_W   = 11;
  localparam int CFG_IDX_W    = 2;
  localparam int RESET_WIDTH  = 640;
  localparam int RESET_HEIGHT = 480;

  // result queue, power of two
  localparam int FIFO_DEPTH = 16;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_FRAME_WIDTH  = 2'd0,
    REG_FRAME_HEIGHT = 2'd1
  } cfg_reg_e;

  typedef enum logic {
    CMD_PIXEL = 1'b0,
    CMD_DRAIN = 1'b1
  } cmd_e;

  // one pixel handed from cell to cell
  typedef struct packed {
    logic valid;
    logic value;
  } tok_t;

endpackage

`default_nettype wire

// ----- rtl/bmed_ram.sv -----
// ----------------------------------------------------------------------------
// bmed_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module bmed_ram #(
  parameter int WIDTH = 2,
  parameter int DEPTH = 1024
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(DEPTH)-1:0] waddr_i,
  input  wire logic [WIDTH-1:0]         wdata_i,
  input  wire logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic      [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

`default_nettype wire

// ----- rtl/bmed_cell.sv -----
// ----------------------------------------------------------------------------
// bmed_cell
// One N x N rectangular erosion or dilation cell with line store and window.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module bmed_cell #(
  parameter int N          = 3,
  parameter bit ERODE      = 1'b1,
  parameter int MAX_WIDTH  = 1024,
  parameter int MAX_HEIGHT = 1024
) (
  input  wire logic                              clk_i,
  input  wire logic                              rst_ni,
  input  wire logic                              clr_i,
  input  wire logic [$clog2(MAX_WIDTH+1)-1:0]    frame_width_i,
  input  wire logic [$clog2(MAX_HEIGHT+1)-1:0]   frame_height_i,
  input  wire bmed_pkg::tok_t                    tok_i,
  output bmed_pkg::tok_t                         tok_o
);
  import bmed_pkg::*;

  localparam int F  = N - 1 - N / 2;
  localparam int WW = $clog2(MAX_WIDTH + 1);
  localparam int CW = $clog2(MAX_WIDTH);
  localparam int RW = $clog2(MAX_HEIGHT) + 2;
  localparam int LW = $clog2(F * MAX_WIDTH + F + 1);
  localparam int LB = N - 1;

  logic [CW-1:0]           qcol_q, qcol_d, qcol_nx;
  logic [LW-1:0]           qcnt_q, qcnt_d, lag_q;
  logic [RW-1:0]           prow_q, prow_d;
  logic [CW-1:0]           pcol_q, pcol_d;
  logic [N-1:0][N-2:0]     win_q;
  logic [N-1:0][N-1:0]     cur;
  logic [N-1:0]            row_ok, col_ok;
  logic                    started;
  logic                    byp_q, byp_d;
  logic [LB-1:0]           bypdata_q, ram_rdata, lb_rd, lb_wdata;
  logic                    acc;
  logic [WW-1:0]           qcol_inc, pcol_inc;
  tok_t                    tok_q, tok_d;

  bmed_ram #(
    .WIDTH (LB),
    .DEPTH (MAX_WIDTH)
  ) u_line (
    .clk_i   (clk_i),
    .we_i    (tok_i.valid),
    .waddr_i (qcol_q),
    .wdata_i (lb_wdata),
    .raddr_i (qcol_d),
    .rdata_o (ram_rdata)
  );

  // one-pixel rows read back the word written in the same cycle
  assign lb_rd    = byp_q ? bypdata_q : ram_rdata;
  assign lb_wdata = {lb_rd[LB-2:0], tok_i.value};
  assign byp_d    = tok_i.valid && (qcol_d == qcol_q);

  assign qcol_inc = WW'(qcol_q) + WW'(1);
  assign qcol_nx  = (qcol_inc == frame_width_i) ? '0 : CW'(qcol_inc);
  assign pcol_inc = WW'(pcol_q) + WW'(1);
  assign started  = (qcnt_q == lag_q);

  always_comb begin
    qcol_d = qcol_q;
    qcnt_d = qcnt_q;
    prow_d = prow_q;
    pcol_d = pcol_q;
    if (clr_i) begin
      qcol_d = '0;
      qcnt_d = '0;
      prow_d = '0;
      pcol_d = '0;
    end else if (tok_i.valid) begin
      qcol_d = qcol_nx;
      if (!started) begin
        qcnt_d = qcnt_q + LW'(1);
      end else if (pcol_inc == frame_width_i) begin
        pcol_d = '0;
        prow_d = prow_q + RW'(1);
      end else begin
        pcol_d = CW'(pcol_inc);
      end
    end
  end

  // window row i holds the row F-i below the output row, column j the pixel F-j right
  always_comb begin
    logic [RW:0]   rsum;
    logic [CW+1:0] csum;
    rsum = (RW+1)'(prow_q) + (RW+1)'(F);
    csum = (CW+2)'(pcol_q) + (CW+2)'(F);
    for (int i = 0; i < N; i++) begin
      row_ok[i] = (rsum >= (RW+1)'(i)) &&
                  ((rsum - (RW+1)'(i)) < (RW+1)'(frame_height_i));
      col_ok[i] = (csum >= (CW+2)'(i)) &&
                  ((csum - (CW+2)'(i)) < (CW+2)'(frame_width_i));
      cur[i][0] = (i == 0) ? tok_i.value : lb_rd[(i == 0) ? 0 : i-1];
      for (int j = 1; j < N; j++) begin
        cur[i][j] = win_q[i][j-1];
      end
    end
  end

  always_comb begin
    acc = ERODE;
    for (int i = 0; i < N; i++) begin
      for (int j = 0; j < N; j++) begin
        if (ERODE) begin
          acc = acc & (cur[i][j] | ~(row_ok[i] & col_ok[j]));
        end else begin
          acc = acc | (cur[i][j] & row_ok[i] & col_ok[j]);
        end
      end
    end
  end

  always_comb begin
    tok_d.valid = tok_i.valid && started && !clr_i;
    tok_d.value = acc;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      qcol_q <= '0;
      qcnt_q <= '0;
      prow_q <= '0;
      pcol_q <= '0;
      tok_q  <= '0;
      byp_q  <= 1'b0;
    end else begin
      qcol_q <= qcol_d;
      qcnt_q <= qcnt_d;
      prow_q <= prow_d;
      pcol_q <= pcol_d;
      tok_q  <= tok_d;
      byp_q  <= byp_d;
    end
  end

  always_ff @(posedge clk_i) begin
    lag_q     <= LW'(frame_width_i) * LW'(F) + LW'(F);
    bypdata_q <= lb_wdata;
    if (tok_i.valid) begin
      for (int i = 0; i < N; i++) begin
        win_q[i] <= cur[i][N-2:0];
      end
    end
  end

  assign tok_o = tok_q;

endmodule

`default_nettype wire

// ----- rtl/binary_mask_erode_dilate_filter.sv -----
// ----------------------------------------------------------------------------
// binary_mask_erode_dilate_filter
// Two 3x3 erosions and two 7x7 dilations of a raster-order binary mask.
// ----------------------------------------------------------------------------
// Throughput: one item per cycle while in_stall_o is low, set by the four window
// cells that each take one pixel per cycle. Result k is released by the transaction
// carrying pixel k + 8*width + 8, then passes the four cells; tail results by drains.
// A pixel that starts a new frame waits until the cell chain has emptied.
// Reset: width 640, height 480, counters cleared; line stores are not cleared.
`timescale 1ns / 1ps
`default_nettype none

module binary_mask_erode_dilate_filter #(
  parameter int MAX_WIDTH   = bmed_pkg::MAX_WIDTH_DEF,
  parameter int MAX_HEIGHT  = bmed_pkg::MAX_HEIGHT_DEF,
  parameter int ERODE_SIZE  = bmed_pkg::ERODE_SIZE_DEF,
  parameter int DILATE_SIZE = bmed_pkg::DILATE_SIZE_DEF
) (
  input  wire logic                            clk_i,
  input  wire logic                            rst_ni,
  input  wire logic                            in_valid_i,
  output logic                                 in_stall_o,
  input  wire logic                            cmd_i,
  input  wire logic                            mask_pixel_i,
  output logic                                 out_valid_o,
  input  wire logic                            out_stall_i,
  output logic                                 filtered_pixel_o,
  output logic                                 frame_last_o,
  input  wire logic                            cfg_valid_i,
  output logic                                 cfg_ready_o,
  input  wire logic [bmed_pkg::CFG_IDX_W-1:0]  cfg_index_i,
  input  wire logic [bmed_pkg::CFG_DATA_W-1:0] cfg_data_i
);
  import bmed_pkg::*;

  localparam int EF    = ERODE_SIZE - 1 - ERODE_SIZE / 2;
  localparam int DF    = DILATE_SIZE - 1 - DILATE_SIZE / 2;
  localparam int LAT   = 2 * EF + 2 * DF;
  localparam int WW    = $clog2(MAX_WIDTH + 1);
  localparam int HW    = $clog2(MAX_HEIGHT + 1);
  localparam int PW    = $clog2(MAX_WIDTH * MAX_HEIGHT + LAT * MAX_WIDTH + LAT + 1);
  localparam int CNT_W = $clog2(FIFO_DEPTH + 1);
  localparam int PTR_W = $clog2(FIFO_DEPTH);
  localparam int RST_W = (RESET_WIDTH > MAX_WIDTH) ? MAX_WIDTH : RESET_WIDTH;
  localparam int RST_H = (RESET_HEIGHT > MAX_HEIGHT) ? MAX_HEIGHT : RESET_HEIGHT;

  logic [WW-1:0]    width_q, width_d, wsat;
  logic [HW-1:0]    height_q, height_d, hsat;
  logic [PW-1:0]    total_q, delay_q;
  logic [PW-1:0]    fed_q, fed_d, fed_base, fed_new;
  logic [PW-1:0]    emitted_q, emitted_d, emit_base;
  logic [PW-1:0]    prod_q, prod_d;
  logic [CNT_W-1:0] owe_q, owe_d, fifo_cnt_q, fifo_cnt_d;
  logic [PTR_W-1:0] wr_ptr_q, rd_ptr_q;
  logic [1:0]       fifo_q [FIFO_DEPTH];
  logic [CNT_W:0]   pending;
  logic             cfg_wait_q;
  logic             cfg_hit, in_acc, pix_acc, drn_acc, frame_done, restart_px, clr;
  logic             owe, flush, push, pop, quiet;
  tok_t             tok_s [5];
  tok_t             feed_d;

  // configuration
  assign cfg_ready_o = 1'b1;
  assign cfg_hit = cfg_valid_i && cfg_ready_o &&
                   (cfg_index_i == REG_FRAME_WIDTH || cfg_index_i == REG_FRAME_HEIGHT);

  always_comb begin
    wsat = (cfg_data_i == '0) ? WW'(1) :
           (32'(cfg_data_i) > 32'(MAX_WIDTH)) ? WW'(MAX_WIDTH) : WW'(cfg_data_i);
    hsat = (cfg_data_i == '0) ? HW'(1) :
           (32'(cfg_data_i) > 32'(MAX_HEIGHT)) ? HW'(MAX_HEIGHT) : HW'(cfg_data_i);
    width_d  = width_q;
    height_d = height_q;
    if (cfg_valid_i && cfg_ready_o) begin
      unique case (cfg_index_i)
        REG_FRAME_WIDTH:  width_d  = wsat;
        REG_FRAME_HEIGHT: height_d = hsat;
        default: ;
      endcase
    end
  end

  // transaction control
  assign quiet = (owe_q == '0) && !tok_s[0].valid && !tok_s[1].valid && !tok_s[2].valid &&
                 !tok_s[3].valid && !tok_s[4].valid;
  assign pending    = (CNT_W+1)'(owe_q) + (CNT_W+1)'(fifo_cnt_q);
  assign frame_done = (fed_q >= total_q);
  assign in_stall_o = cfg_wait_q || (pending >= (CNT_W+1)'(FIFO_DEPTH)) ||
                      ((cmd_i == CMD_PIXEL) && frame_done && !quiet);

  assign in_acc     = in_valid_i && !in_stall_o;
  assign pix_acc    = in_acc && (cmd_i == CMD_PIXEL);
  assign drn_acc    = in_acc && (cmd_i == CMD_DRAIN);
  assign restart_px = pix_acc && frame_done;
  assign clr        = cfg_hit || restart_px;

  assign fed_base  = restart_px ? '0 : fed_q;
  assign fed_new   = fed_base + PW'(1);
  assign emit_base = restart_px ? '0 : emitted_q;

  always_comb begin
    owe = 1'b0;
    if (pix_acc) begin
      owe = (emit_base < total_q) && ((fed_new - emit_base) > delay_q);
    end else if (drn_acc) begin
      owe = frame_done && (emitted_q < total_q);
    end
  end

  // padding pixels past the frame end, only as far as owed results need
  assign flush = !pix_acc && !clr && frame_done &&
                 ((PW+1)'(fed_q) < (PW+1)'(emitted_q) + (PW+1)'(delay_q));

  always_comb begin
    feed_d.valid = pix_acc || flush;
    feed_d.value = pix_acc && mask_pixel_i;
    if (cfg_hit) begin
      fed_d     = '0;
      emitted_d = '0;
    end else begin
      fed_d     = pix_acc ? fed_new : (flush ? fed_q + PW'(1) : fed_q);
      emitted_d = emit_base + PW'(owe);
    end
  end

  bmed_cell #(
    .N (ERODE_SIZE), .ERODE (1'b1), .MAX_WIDTH (MAX_WIDTH), .MAX_HEIGHT (MAX_HEIGHT)
  ) u_erode0 (
    .clk_i (clk_i), .rst_ni (rst_ni), .clr_i (clr),
    .frame_width_i (width_q), .frame_height_i (height_q),
    .tok_i (tok_s[0]), .tok_o (tok_s[1])
  );

  bmed_cell #(
    .N (ERODE_SIZE), .ERODE (1'b1), .MAX_WIDTH (MAX_WIDTH), .MAX_HEIGHT (MAX_HEIGHT)
  ) u_erode1 (
    .clk_i (clk_i), .rst_ni (rst_ni), .clr_i (clr),
    .frame_width_i (width_q), .frame_height_i (height_q),
    .tok_i (tok_s[1]), .tok_o (tok_s[2])
  );

  bmed_cell #(
    .N (DILATE_SIZE), .ERODE (1'b0), .MAX_WIDTH (MAX_WIDTH), .MAX_HEIGHT (MAX_HEIGHT)
  ) u_dilate0 (
    .clk_i (clk_i), .rst_ni (rst_ni), .clr_i (clr),
    .frame_width_i (width_q), .frame_height_i (height_q),
    .tok_i (tok_s[2]), .tok_o (tok_s[3])
  );

  bmed_cell #(
    .N (DILATE_SIZE), .ERODE (1'b0), .MAX_WIDTH (MAX_WIDTH), .MAX_HEIGHT (MAX_HEIGHT)
  ) u_dilate1 (
    .clk_i (clk_i), .rst_ni (rst_ni), .clr_i (clr),
    .frame_width_i (width_q), .frame_height_i (height_q),
    .tok_i (tok_s[3]), .tok_o (tok_s[4])
  );

  // result queue
  assign push       = tok_s[4].valid && (prod_q < total_q);
  assign pop        = out_valid_o && !out_stall_i;
  assign prod_d     = clr ? '0 : prod_q + PW'(tok_s[4].valid);
  assign owe_d      = owe_q + CNT_W'(owe) - CNT_W'(push);
  assign fifo_cnt_d = fifo_cnt_q + CNT_W'(push) - CNT_W'(pop);

  assign out_valid_o      = (fifo_cnt_q != '0);
  assign filtered_pixel_o = fifo_q[rd_ptr_q][0];
  assign frame_last_o     = fifo_q[rd_ptr_q][1];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      width_q    <= WW'(RST_W);
      height_q   <= HW'(RST_H);
      total_q    <= PW'(RST_W * RST_H);
      delay_q    <= PW'(LAT * RST_W + LAT);
      cfg_wait_q <= 1'b0;
      fed_q      <= '0;
      emitted_q  <= '0;
      prod_q     <= '0;
      owe_q      <= '0;
      fifo_cnt_q <= '0;
      wr_ptr_q   <= '0;
      rd_ptr_q   <= '0;
      tok_s[0]   <= '0;
    end else begin
      width_q    <= width_d;
      height_q   <= height_d;
      total_q    <= PW'(width_q) * PW'(height_q);
      delay_q    <= PW'(width_q) * PW'(LAT) + PW'(LAT);
      cfg_wait_q <= cfg_valid_i && cfg_ready_o;
      fed_q      <= fed_d;
      emitted_q  <= emitted_d;
      prod_q     <= prod_d;
      owe_q      <= owe_d;
      fifo_cnt_q <= fifo_cnt_d;
      tok_s[0]   <= feed_d;
      if (push) begin
        wr_ptr_q <= wr_ptr_q + PTR_W'(1);
      end
      if (pop) begin
        rd_ptr_q <= rd_ptr_q + PTR_W'(1);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      fifo_q[wr_ptr_q] <= {(prod_q == total_q - PW'(1)), tok_s[4].value};
    end
  end

  // checks
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    fifo_cnt_q <= CNT_W'(FIFO_DEPTH))
    else $error("result queue overflow");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    pending <= (CNT_W+1)'(FIFO_DEPTH))
    else $error("owed results exceed queue space");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    tok_s[4].valid |-> (owe_q != '0))
    else $error("cell chain produced a result nobody owes");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    restart_px |-> !flush && quiet)
    else $error("frame restart while the cell chain is busy");

endmodule

`default_nettype wire
